// File: rtl/sqh_pkg.sv
// Shared types and constants for the subband quantizer and level histogram.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package sqh_pkg;

  localparam int FUNC_W    = 2;
  localparam int BAND_W    = 3;
  localparam int COEFF_W   = 32;
  localparam int BIN_W     = 10;
  localparam int SIGN_W    = 2;
  localparam int MAG_W     = 32;
  localparam int LEVEL_W   = 10;
  localparam int READ_W    = 32;
  localparam int DELTA_W   = 24;
  localparam int PROD_HI_W = MAG_W + DELTA_W - 32;

  localparam logic [DELTA_W-1:0] DELTA_RESET = 24'd65536;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_QUANT    = 2'd0,
    FUNC_READ_BIN = 2'd1,
    FUNC_READ_MAX = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [SIGN_W-1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_code_t;

endpackage

// File: rtl/sqh_channels.sv
// Valid/ready channel interfaces for requests and results.
// Depends on sqh_pkg for field widths.
`timescale 1ns / 1ps

interface sqh_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [sqh_pkg::FUNC_W-1:0]           func;
  logic [sqh_pkg::BAND_W-1:0]           band;
  logic signed [sqh_pkg::COEFF_W-1:0]   coeff;
  logic [sqh_pkg::BIN_W-1:0]            bin;

  modport source (output valid, func, band, coeff, bin, input ready);
  modport sink   (input valid, func, band, coeff, bin, output ready);
endinterface

interface sqh_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sqh_pkg::SIGN_W-1:0]    sign_code;
  logic [sqh_pkg::MAG_W-1:0]     magnitude;
  logic [sqh_pkg::LEVEL_W-1:0]   level;
  logic                          saturated;
  logic [sqh_pkg::READ_W-1:0]    read_value;

  modport source (output valid, sign_code, magnitude, level, saturated, read_value,
                  input ready);
  modport sink   (input valid, sign_code, magnitude, level, saturated, read_value,
                  output ready);
endinterface

// File: rtl/subband_quantize_histogram_unit.sv
// Subband quantizer with per-band level histogram and band maximum.
// Depends on sqh_pkg and the channel interfaces in sqh_channels.sv.
//
//   channel   dir   handshake       payload
//   req       in    valid/ready     func, band, coeff, bin
//   rsp       out   valid/ready     sign_code, magnitude, level, saturated, read_value
//   cfg       in    cfg_wr_en       cfg_wr_data (delta_scale)
//
// One request is worked at a time. Quantize steps: magnitude, multiply,
// saturate, histogram read, increment/write, result load; histogram read:
// read, capture, result load; band max read: result load; clear band: the
// single write port of the histogram memory sweeps the band one bin per cycle.
// After reset a clearing pass writes all BANDS*BINS entries, one per cycle,
// before the first request is taken. A finished result waits in the output
// register while the next request is accepted; a stalled rsp holds only the
// final step of the following request.
`timescale 1ns / 1ps

module subband_quantize_histogram_unit #(
  parameter int BINS       = 1024,
  parameter int BANDS      = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sqh_pkg::DELTA_W-1:0]   cfg_wr_data,
  sqh_req_if.sink                       req,
  sqh_rsp_if.source                     rsp
);

  localparam int DEPTH   = BANDS * BINS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LVL_W   = $clog2(BINS);
  localparam int BAND_IW = (BANDS > 1) ? $clog2(BANDS) : 1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_LVL,
    ST_RD,
    ST_INC,
    ST_HRD,
    ST_CLR,
    ST_DONE
  } state_t;

  state_t state;

  logic [sqh_pkg::DELTA_W-1:0]   delta_scale;
  logic [sqh_pkg::LEVEL_W-1:0]   band_max [BANDS];

  logic [sqh_pkg::FUNC_W-1:0]    func_q;
  logic [sqh_pkg::BAND_W-1:0]    band_q;
  logic                          band_ok_q;
  logic [sqh_pkg::MAG_W-1:0]     mag_q;
  logic [sqh_pkg::PROD_HI_W-1:0] prod_hi;
  logic [ADDR_W-1:0]             addr_q;
  logic [ADDR_W-1:0]             cnt;

  logic [sqh_pkg::SIGN_W-1:0]    res_sign;
  logic [sqh_pkg::MAG_W-1:0]     res_mag;
  logic [sqh_pkg::LEVEL_W-1:0]   res_level;
  logic                          res_sat;
  logic [sqh_pkg::READ_W-1:0]    res_read;

  logic [COUNT_BITS-1:0]         hist [DEPTH];
  logic [COUNT_BITS-1:0]         mem_rdata;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [COUNT_BITS-1:0]         mem_wdata;

  // request-side decode
  logic                          req_fire;
  logic                          req_band_ok;
  logic                          req_bin_ok;
  logic [BAND_IW-1:0]            req_bidx;
  logic [ADDR_W-1:0]             req_base;
  logic [sqh_pkg::MAG_W-1:0]     req_mag;
  logic [sqh_pkg::SIGN_W-1:0]    req_sign;

  // quantize decode
  logic [sqh_pkg::MAG_W+sqh_pkg::DELTA_W-1:0] prod;
  logic                          lvl_sat;
  logic [LVL_W-1:0]              lvl;
  logic [BAND_IW-1:0]            bidx_q;
  logic [ADDR_W-1:0]             lvl_addr;
  logic                          out_free;

  assign req.ready   = (state == ST_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign req_band_ok = 32'(req.band) < BANDS;
  assign req_bin_ok  = 32'(req.bin) < BINS;
  assign req_bidx    = BAND_IW'(req.band);
  assign req_base    = ADDR_W'(ADDR_W'(req.band) * ADDR_W'(BINS));

  always_comb begin
    if (req.coeff == '0) begin
      req_sign = sqh_pkg::SIGN_ZERO;
    end else if (req.coeff[sqh_pkg::COEFF_W-1]) begin
      req_sign = sqh_pkg::SIGN_NEG;
    end else begin
      req_sign = sqh_pkg::SIGN_POS;
    end
  end

  // the most negative coefficient negates to itself, as wanted
  assign req_mag = req.coeff[sqh_pkg::COEFF_W-1] ? sqh_pkg::MAG_W'(-req.coeff)
                                                 : sqh_pkg::MAG_W'(req.coeff);

  assign prod     = mag_q * delta_scale;
  assign lvl_sat  = 32'(prod_hi) > (BINS - 1);
  assign lvl      = lvl_sat ? LVL_W'(BINS - 1) : LVL_W'(prod_hi);
  assign bidx_q   = BAND_IW'(band_q);
  assign lvl_addr = ADDR_W'(ADDR_W'(ADDR_W'(band_q) * ADDR_W'(BINS)) + ADDR_W'(lvl));
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    case (state)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(addr_q + cnt);
      end
      ST_INC: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = COUNT_BITS'(mem_rdata + 1'b1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= hist[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cnt         <= '0;
      delta_scale <= sqh_pkg::DELTA_RESET;
      rsp.valid   <= 1'b0;
      for (int i = 0; i < BANDS; i++) begin
        band_max[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        delta_scale <= cfg_wr_data;
      end
      // a waiting result that leaves is replaced in ST_DONE when one is ready
      if (rsp.valid && rsp.ready && state != ST_DONE) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        ST_INIT: begin
          cnt <= ADDR_W'(cnt + 1'b1);
          if (cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req_fire) begin
            func_q    <= req.func;
            band_q    <= req.band;
            band_ok_q <= req_band_ok;
            mag_q     <= req_mag;
            res_level <= '0;
            res_sat   <= 1'b0;
            cnt       <= '0;
            res_sign  <= (req.func == sqh_pkg::FUNC_QUANT) ? req_sign : sqh_pkg::SIGN_ZERO;
            res_mag   <= (req.func == sqh_pkg::FUNC_QUANT) ? req_mag : '0;
            res_read  <= (req.func == sqh_pkg::FUNC_READ_MAX && req_band_ok)
                         ? sqh_pkg::READ_W'(band_max[req_bidx]) : '0;
            addr_q    <= (req.func == sqh_pkg::FUNC_CLEAR) ? req_base
                         : ADDR_W'(req_base + ADDR_W'(req.bin));
            case (req.func)
              sqh_pkg::FUNC_QUANT: begin
                state <= ST_MUL;
              end
              sqh_pkg::FUNC_READ_BIN: begin
                state <= (req_band_ok && req_bin_ok) ? ST_RD : ST_DONE;
              end
              sqh_pkg::FUNC_READ_MAX: begin
                state <= ST_DONE;
              end
              default: begin
                if (req_band_ok) begin
                  band_max[req_bidx] <= '0;
                  state              <= ST_CLR;
                end else begin
                  state <= ST_DONE;
                end
              end
            endcase
          end
        end

        ST_MUL: begin
          prod_hi <= prod[sqh_pkg::MAG_W+sqh_pkg::DELTA_W-1:32];
          state   <= ST_LVL;
        end

        ST_LVL: begin
          res_level <= sqh_pkg::LEVEL_W'(lvl);
          res_sat   <= lvl_sat;
          addr_q    <= lvl_addr;
          if (band_ok_q) begin
            if (32'(lvl) > 32'(band_max[bidx_q])) begin
              band_max[bidx_q] <= sqh_pkg::LEVEL_W'(lvl);
            end
            state <= ST_RD;
          end else begin
            state <= ST_DONE;
          end
        end

        // histogram entry is being read; data arrives next cycle
        ST_RD: begin
          state <= (func_q == sqh_pkg::FUNC_QUANT) ? ST_INC : ST_HRD;
        end

        ST_INC: begin
          state <= ST_DONE;
        end

        ST_HRD: begin
          res_read <= sqh_pkg::READ_W'(mem_rdata);
          state    <= ST_DONE;
        end

        ST_CLR: begin
          cnt <= ADDR_W'(cnt + 1'b1);
          if (cnt == ADDR_W'(BINS - 1)) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.sign_code  <= res_sign;
            rsp.magnitude  <= res_mag;
            rsp.level      <= res_level;
            rsp.saturated  <= res_sat;
            rsp.read_value <= res_read;
            state          <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a completed request");

  a_inc_after_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INC) |-> $past(state == ST_RD, 1) && $past(state == ST_LVL, 2))
    else $error("histogram write-back without its read");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req.ready)
    else $error("second request accepted while one is in progress");

endmodule

// File: dv/subband_quantize_histogram_unit_tb.sv
// Self-checking bench for subband_quantize_histogram_unit: a request table, then random
// requests over several step settings, checked by table rows or an in-bench histogram.
// Depends on sqh_pkg, sqh_channels.sv and the unit itself.
`timescale 1ns / 1ps

module subband_quantize_histogram_unit_tb;

  localparam int BINS          = 1024;
  localparam int BANDS         = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 250;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    sqh_pkg::func_t                     func;
    logic [sqh_pkg::BAND_W-1:0]         band;
    logic signed [sqh_pkg::COEFF_W-1:0] coeff;
    logic [sqh_pkg::BIN_W-1:0]          bin;
  } req_item_t;

  typedef struct packed {
    sqh_pkg::sign_code_t          sign_code;
    logic [sqh_pkg::MAG_W-1:0]    magnitude;
    logic [sqh_pkg::LEVEL_W-1:0]  level;
    logic                         saturated;
    logic [sqh_pkg::READ_W-1:0]   read_value;
  } rsp_item_t;

  typedef struct packed {
    req_item_t rq;
    logic      known;
    rsp_item_t rs;
  } table_row_t;

  localparam int TABLE_ROWS = 25;

  // Known results assume the reset step of 1.0.
  localparam table_row_t REQUEST_TABLE [TABLE_ROWS] = '{
    '{'{sqh_pkg::FUNC_READ_MAX, 3'd0, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd7, 32'sh0, 10'd1023}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd0, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd1, 32'sh80000000, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_NEG, 32'h80000000, 10'd1023, 1'b1, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd1, 32'sh7fffffff, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_POS, 32'h7fffffff, 10'd1023, 1'b1, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd2, 32'sh1, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_POS, 32'h1, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd2, 32'shffffffff, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_NEG, 32'h1, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd3, 32'sh03ff0000, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_POS, 32'h03ff0000, 10'd1023, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd3, 32'sh04000000, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_POS, 32'h04000000, 10'd1023, 1'b1, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd3, 32'shfffb0000, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_NEG, 32'h00050000, 10'd5, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd3, 32'sh0, 10'd1023}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd2}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd1, 32'sh0, 10'd1023}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd2}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd2, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd2}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd0, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd1}},
    '{'{sqh_pkg::FUNC_READ_MAX, 3'd3, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd1023}},
    '{'{sqh_pkg::FUNC_READ_MAX, 3'd2, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_CLEAR, 3'd3, 32'sh12345678, 10'h2aa}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd3, 32'sh0, 10'd1023}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd3, 32'sh0, 10'd5}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_READ_MAX, 3'd3, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_READ_BIN, 3'd1, 32'sh0, 10'd1023}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd2}},
    '{'{sqh_pkg::FUNC_CLEAR, 3'd7, 32'sh0, 10'd0}, 1'b1,
      '{sqh_pkg::SIGN_ZERO, 32'h0, 10'd0, 1'b0, 32'd0}},
    '{'{sqh_pkg::FUNC_QUANT, 3'd7, 32'sh00128000, 10'h155}, 1'b0, '0},
    '{'{sqh_pkg::FUNC_READ_MAX, 3'd7, 32'shffffffff, 10'h3ff}, 1'b0, '0},
    '{'{sqh_pkg::FUNC_QUANT, 3'd5, 32'sha5a5a5a5, 10'd0}, 1'b0, '0}
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [sqh_pkg::DELTA_W-1:0] cfg_wr_data;

  sqh_req_if req ();
  sqh_rsp_if rsp ();

  subband_quantize_histogram_unit #(
    .BINS       (BINS),
    .BANDS      (BANDS),
    .COUNT_BITS (32)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  // Shadow of the unit's state
  logic [sqh_pkg::DELTA_W-1:0] step_recip;
  logic [31:0]                 level_count [BANDS][BINS];
  logic [sqh_pkg::LEVEL_W-1:0] peak_level [BANDS];
  logic [sqh_pkg::LEVEL_W-1:0] recent_level [BANDS];

  rsp_item_t pending_results [$];

  bit idle_on;
  int errors;
  int cycle_count;
  int results_seen;
  int settings_used;
  int n_quant, n_sat, n_read_bin, n_read_max, n_clear;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic rsp_item_t quantize_and_tally(input req_item_t r);
    rsp_item_t                  o;
    logic [sqh_pkg::MAG_W-1:0]  mag;
    logic [63:0]                prod;
    o = '0;
    case (r.func)
      sqh_pkg::FUNC_QUANT: begin
        mag = r.coeff[sqh_pkg::COEFF_W-1] ? (~r.coeff + 32'd1) : r.coeff;
        if (r.coeff != 0) begin
          o.sign_code = r.coeff[sqh_pkg::COEFF_W-1] ? sqh_pkg::SIGN_NEG : sqh_pkg::SIGN_POS;
        end
        prod = {32'd0, mag} * {40'd0, step_recip};
        if (prod[63:32] > BINS - 1) begin
          o.level     = sqh_pkg::LEVEL_W'(BINS - 1);
          o.saturated = 1'b1;
        end else begin
          o.level = prod[32 +: sqh_pkg::LEVEL_W];
        end
        o.magnitude = mag;
        level_count[r.band][o.level] = level_count[r.band][o.level] + 32'd1;
        if (o.level > peak_level[r.band]) peak_level[r.band] = o.level;
      end
      sqh_pkg::FUNC_READ_BIN: o.read_value = level_count[r.band][r.bin];
      sqh_pkg::FUNC_READ_MAX: o.read_value = sqh_pkg::READ_W'(peak_level[r.band]);
      default: begin
        for (int b = 0; b < BINS; b++) level_count[r.band][b] = '0;
        peak_level[r.band] = '0;
      end
    endcase
    return o;
  endfunction

  // Mostly coefficients whose levels spread from bin 0 to just past the clip point,
  // plus corner values and raw 32-bit noise; reads lean toward recently hit bins.
  function automatic req_item_t draw_request();
    req_item_t                  r;
    int                         pick;
    logic [63:0]                span;
    logic [sqh_pkg::MAG_W-1:0]  mag;
    r.band  = sqh_pkg::BAND_W'($urandom_range(0, BANDS - 1));
    r.coeff = $urandom;
    r.bin   = sqh_pkg::BIN_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 68) r.func = sqh_pkg::FUNC_QUANT;
    else if (pick < 84) r.func = sqh_pkg::FUNC_READ_BIN;
    else if (pick < 96) r.func = sqh_pkg::FUNC_READ_MAX;
    else r.func = sqh_pkg::FUNC_CLEAR;
    if (r.func == sqh_pkg::FUNC_QUANT) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        case ($urandom_range(0, 4))
          0: r.coeff = 32'sh0;
          1: r.coeff = 32'sh80000000;
          2: r.coeff = 32'sh7fffffff;
          3: r.coeff = 32'sh1;
          default: r.coeff = -32'sh1;
        endcase
      end else if (pick >= 20) begin
        span = (step_recip == '0) ? 64'h7fffffff : ((64'd1100 << 32) / step_recip);
        if (span > 64'h7fffffff) span = 64'h7fffffff;
        mag = $urandom_range(0, span[31:0]);
        r.coeff = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
      end
    end else if (r.func == sqh_pkg::FUNC_READ_BIN && $urandom_range(0, 9) < 7) begin
      r.bin = recent_level[r.band] + sqh_pkg::BIN_W'($urandom_range(0, 2)) - sqh_pkg::BIN_W'(1);
    end
    return r;
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance.
  task automatic send_request(input req_item_t r, input logic known, input rsp_item_t fixed);
    int        gap;
    rsp_item_t res;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= r.func;
    req.band  <= r.band;
    req.coeff <= r.coeff;
    req.bin   <= r.bin;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    res = quantize_and_tally(r);
    pending_results.push_back(known ? fixed : res);
    case (r.func)
      sqh_pkg::FUNC_QUANT: begin
        n_quant++;
        n_sat += res.saturated;
        recent_level[r.band] = res.level;
      end
      sqh_pkg::FUNC_READ_BIN: n_read_bin++;
      sqh_pkg::FUNC_READ_MAX: n_read_max++;
      default: n_clear++;
    endcase
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result is back and the unit is quiet.
  task automatic settle_unit();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_step(input logic [sqh_pkg::DELTA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    step_recip  = value;
    settings_used++;
  endtask

  task automatic check_result(input rsp_item_t want);
    if (rsp.sign_code !== want.sign_code) begin
      $error("sign_code: expected %0d, got %0d", want.sign_code, rsp.sign_code);
      errors++;
    end
    if (rsp.magnitude !== want.magnitude) begin
      $error("magnitude: expected %h, got %h", want.magnitude, rsp.magnitude);
      errors++;
    end
    if (rsp.level !== want.level) begin
      $error("level: expected %0d, got %0d", want.level, rsp.level);
      errors++;
    end
    if (rsp.saturated !== want.saturated) begin
      $error("saturated: expected %0d, got %0d", want.saturated, rsp.saturated);
      errors++;
    end
    if (rsp.read_value !== want.read_value) begin
      $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
      errors++;
    end
  endtask

  // Result side: random stalls, plus two long holds so the unit backs up.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (results_seen == 300 || results_seen == 1100) stall = LONG_HOLD;
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        check_result(pending_results.pop_front());
      end
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results owed", cycle_count,
             pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [sqh_pkg::DELTA_W-1:0] phase_step [PHASES];
    phase_step = '{24'h000000, 24'hffffff, 24'h010000, 24'h000100,
                   24'h004000, 24'h100000, 24'h000000, 24'h000000};
    phase_step[6] = sqh_pkg::DELTA_W'($urandom);
    phase_step[7] = sqh_pkg::DELTA_W'($urandom_range(24'h8000, 24'h40000));

    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    req.valid   = 1'b0;
    req.func    = sqh_pkg::FUNC_QUANT;
    req.band    = '0;
    req.coeff   = '0;
    req.bin     = '0;
    idle_on     = 1'b1;
    step_recip  = sqh_pkg::DELTA_RESET;
    foreach (level_count[b, i]) level_count[b][i] = '0;
    foreach (peak_level[b]) begin
      peak_level[b]   = '0;
      recent_level[b] = '0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_step(sqh_pkg::DELTA_RESET);

    for (int i = 0; i < TABLE_ROWS; i++)
      send_request(REQUEST_TABLE[i].rq, REQUEST_TABLE[i].known, REQUEST_TABLE[i].rs);

    for (int p = 0; p < PHASES; p++) begin
      settle_unit();
      write_step(phase_step[p]);
      idle_on = (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(draw_request(), 1'b0, '0);
    end

    settle_unit();
    $display("Sent %0d requests: %0d quantize (%0d clipped), %0d bin reads, %0d max reads,",
             n_quant + n_read_bin + n_read_max + n_clear, n_quant, n_sat, n_read_bin,
             n_read_max);
    $display("%0d clears; checked %0d results over %0d step settings in %0d cycles, %0d mismatches",
             n_clear, results_seen, settings_used, cycle_count, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: subband_quantize_histogram_unit.f
rtl/sqh_pkg.sv
rtl/sqh_channels.sv
rtl/subband_quantize_histogram_unit.sv
dv/subband_quantize_histogram_unit_tb.sv
